/* src/pftb_pkg.sv */
package pftb_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_PALETTE_MODE = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_FOG_ENABLE   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_FOG_COLOR    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_DARKNESS     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_BLEND_COLOR  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_PRIM_COLOR   = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_ENV_COLOR    = 3'd6;

  localparam logic [7:0]  DARKNESS_RST = 8'd180;
  localparam logic [23:0] PRIM_RST     = 24'hFFFFFF;
  localparam logic [7:0]  FULL_WEIGHT  = 8'hFF;
  localparam logic [4:0]  CH_MAX       = 5'h1F;
  localparam logic [15:0] OPAQUE_BLACK = 16'h0001;

  typedef struct packed {
    logic load_in;
    logic do_mix;
    logic load_out;
  } pftb_cmd_t;

  // floor(x / 255) for x <= 65025
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
    return s[15:8];
  endfunction

  function automatic logic [7:0] mix255(input logic [7:0] f, input logic [7:0] b,
                                        input logic [7:0] a);
    logic [15:0] n;
    n = ({8'b0, f} * {8'b0, (8'd255 - a)}) + ({8'b0, b} * {8'b0, a});
    return div255(n);
  endfunction

  // c + (t - c) * w / 256, quotient truncated toward zero
  function automatic logic [4:0] lerp5(input logic [4:0] c, input logic [4:0] t,
                                       input logic [7:0] w);
    logic signed [5:0]  diff;
    logic signed [14:0] prod;
    logic signed [14:0] adj;
    logic signed [14:0] quo;
    logic [6:0]         sum;
    diff = $signed({1'b0, t}) - $signed({1'b0, c});
    prod = 15'(diff) * $signed({7'b0, w});
    adj  = prod[14] ? (prod + 15'sd255) : prod;
    quo  = adj >>> 8;
    sum  = {2'b00, c} + quo[6:0];
    return sum[4:0];
  endfunction

  // c * p / 256 + e / 8, saturated
  function automatic logic [4:0] modulate5(input logic [4:0] c, input logic [7:0] p,
                                           input logic [7:0] e);
    logic [12:0] prod;
    logic [5:0]  sum;
    prod = {8'b0, c} * {5'b0, p};
    sum  = {1'b0, prod[12:8]} + {1'b0, e[7:3]};
    return sum[5] ? CH_MAX : sum[4:0];
  endfunction

endpackage

/* src/pftb_ctrl.sv */
module pftb_ctrl
  import pftb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output pftb_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MIX  = 2'd1;
  localparam logic [1:0] ST_LERP = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       load_out, accept;

  assign load_out  = (state_r == ST_LERP) && (!out_valid_r || !out_stall);
  assign in_stall  = !((state_r == ST_IDLE) || load_out);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  assign cmd.load_in  = accept;
  assign cmd.do_mix   = (state_r == ST_MIX);
  assign cmd.load_out = load_out;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: state_nxt = accept ? ST_MIX : ST_IDLE;
      ST_MIX:  state_nxt = ST_LERP;
      ST_LERP: begin
        if (load_out) begin
          state_nxt = accept ? ST_MIX : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* src/pftb_datapath.sv */
module pftb_datapath
  import pftb_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  pftb_cmd_t           cmd,
  input  logic                cfg_wr,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic [15:0]         palette_color,
  output logic [15:0]         tinted_color,
  output logic                tint_applied
);

  logic        palette_mode_r;
  logic        fog_enable_r;
  logic [23:0] fog_color_r;
  logic [7:0]  darkness_r;
  logic [31:0] blend_color_r;
  logic [23:0] prim_color_r;
  logic [23:0] env_color_r;
  logic        tint_active_r, tint_active_nxt;

  logic [15:0] pc_r;
  logic [15:0] pc2_r;
  logic [4:0]  tr_r, tg_r, tb_r;
  logic [7:0]  w_r;
  logic [15:0] tinted_r;
  logic        applied_r;

  logic [7:0]  a1, tr_nxt, tg_nxt, tb_nxt, w_nxt;
  logic        fog, bl, ident;
  logic [4:0]  cr, cg, cb;
  logic [15:0] res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      palette_mode_r <= 1'b0;
      fog_enable_r   <= 1'b0;
      fog_color_r    <= '0;
      darkness_r     <= DARKNESS_RST;
      blend_color_r  <= '0;
      prim_color_r   <= PRIM_RST;
      env_color_r    <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_PALETTE_MODE: palette_mode_r <= cfg_data[0];
        CFG_FOG_ENABLE:   fog_enable_r   <= cfg_data[0];
        CFG_FOG_COLOR:    fog_color_r    <= cfg_data[23:0];
        CFG_DARKNESS:     darkness_r     <= cfg_data[7:0];
        CFG_BLEND_COLOR:  blend_color_r  <= cfg_data;
        CFG_PRIM_COLOR:   prim_color_r   <= cfg_data[23:0];
        CFG_ENV_COLOR:    env_color_r    <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // mix stage: target color, weight and tint state
  assign a1    = blend_color_r[7:0];
  assign fog   = fog_enable_r;
  assign bl    = (a1 != 8'd0);
  assign ident = (prim_color_r == PRIM_RST) && (env_color_r == 24'd0);

  always_comb begin
    if (!palette_mode_r) begin
      tint_active_nxt = fog || bl;
    end else if (fog) begin
      tint_active_nxt = ident ? 1'b1 : tint_active_r;
    end else begin
      tint_active_nxt = !ident;
    end
  end

  always_comb begin
    priority if (fog && bl) begin
      tr_nxt = mix255(fog_color_r[23:16], blend_color_r[31:24], a1);
      tg_nxt = mix255(fog_color_r[15:8], blend_color_r[23:16], a1);
      tb_nxt = mix255(fog_color_r[7:0], blend_color_r[15:8], a1);
      w_nxt  = mix255(darkness_r, a1, a1);
    end else if (fog) begin
      tr_nxt = fog_color_r[23:16];
      tg_nxt = fog_color_r[15:8];
      tb_nxt = fog_color_r[7:0];
      w_nxt  = darkness_r;
    end else begin
      tr_nxt = blend_color_r[31:24];
      tg_nxt = blend_color_r[23:16];
      tb_nxt = blend_color_r[15:8];
      w_nxt  = a1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tint_active_r <= 1'b0;
    end else if (cmd.do_mix) begin
      tint_active_r <= tint_active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      pc_r <= palette_color;
    end
    if (cmd.do_mix) begin
      pc2_r <= pc_r;
      tr_r  <= tr_nxt[7:3];
      tg_r  <= tg_nxt[7:3];
      tb_r  <= tb_nxt[7:3];
      w_r   <= w_nxt;
    end
  end

  // lerp / modulate stage
  assign cr = pc2_r[15:11];
  assign cg = pc2_r[10:6];
  assign cb = pc2_r[5:1];

  always_comb begin
    res = pc2_r;
    if (tint_active_r) begin
      if (palette_mode_r) begin
        res = {modulate5(cr, prim_color_r[23:16], env_color_r[23:16]),
               modulate5(cg, prim_color_r[15:8], env_color_r[15:8]),
               modulate5(cb, prim_color_r[7:0], env_color_r[7:0]), 1'b1};
      end else if (w_r == FULL_WEIGHT) begin
        res = OPAQUE_BLACK;
      end else begin
        res = {lerp5(cr, tr_r, w_r), lerp5(cg, tg_r, w_r), lerp5(cb, tb_r, w_r), 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      tinted_r  <= res;
      applied_r <= tint_active_r;
    end
  end

  assign tinted_color = tinted_r;
  assign tint_applied = applied_r;

endmodule

/* src/palette_fog_tint_blender_top.sv */
// Palette tint blender: recolors one RGBA5551 palette entry per request, either
// lerping toward a fog/blend color (opaque black at full weight) or modulating by
// prim and adding env, with a sticky tint-active flag that passes the entry through
// when clear. A request goes through the mix stage, then the lerp/modulate stage into
// the output register. A new request is accepted while idle, also while the last
// result waits in the output register, or as a result loads into it. Configuration
// writes are always ready and must only be issued while the block is idle.
module palette_fog_tint_blender_top
  import pftb_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [15:0]         in_palette_color,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [15:0]         out_tinted_color,
  output logic                out_tint_applied,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  pftb_cmd_t cmd;

  assign cfg_ready = 1'b1;

  pftb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  pftb_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .cfg_wr        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .palette_color (in_palette_color),
    .tinted_color  (out_tinted_color),
    .tint_applied  (out_tint_applied)
  );

endmodule
